// ===== rtl/trsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package trsp_pkg;

   // Byte roles reported with every result.
   localparam logic [2:0] ROLE_TAG     = 3'd0;
   localparam logic [2:0] ROLE_LEN     = 3'd1;
   localparam logic [2:0] ROLE_PAYLOAD = 3'd2;
   localparam logic [2:0] ROLE_CR      = 3'd3;
   localparam logic [2:0] ROLE_LF      = 3'd4;
   localparam logic [2:0] ROLE_DISCARD = 3'd5;

   // Value kinds.
   localparam logic [2:0] KIND_NONE   = 3'd0;
   localparam logic [2:0] KIND_SIMPLE = 3'd1;
   localparam logic [2:0] KIND_ERROR  = 3'd2;
   localparam logic [2:0] KIND_INT    = 3'd3;
   localparam logic [2:0] KIND_BULK   = 3'd4;
   localparam logic [2:0] KIND_ARRAY  = 3'd5;
   localparam logic [2:0] KIND_NULL   = 3'd6;

   // Error codes.
   localparam logic [2:0] ERR_OK        = 3'd0;
   localparam logic [2:0] ERR_BAD_TAG   = 3'd1;
   localparam logic [2:0] ERR_BAD_CRLF  = 3'd2;
   localparam logic [2:0] ERR_TRUNCATED = 3'd3;
   localparam logic [2:0] ERR_TOO_DEEP  = 3'd4;

   // Characters of the wire format.
   localparam logic [7:0] CH_CR     = 8'h0d;
   localparam logic [7:0] CH_LF     = 8'h0a;
   localparam logic [7:0] CH_NULL   = 8'h5f;
   localparam logic [7:0] CH_ERROR  = 8'h2d;
   localparam logic [7:0] CH_SIMPLE = 8'h2b;
   localparam logic [7:0] CH_INT    = 8'h3a;
   localparam logic [7:0] CH_BULK   = 8'h24;
   localparam logic [7:0] CH_ARRAY  = 8'h2a;

   // An int64 value carries eight raw payload bytes.
   localparam logic [31:0] INT_PAYLOAD_BYTES = 32'd8;

   typedef struct packed {
      logic [7:0] rx_byte;
      logic       end_of_buffer;
   } req_type;

   typedef struct packed {
      logic [2:0]  byte_role;
      logic [2:0]  value_kind;
      logic [7:0]  payload_byte;
      logic [3:0]  nest_depth;
      logic        value_done;
      logic        reply_done;
      logic [31:0] length_value;
      logic [2:0]  error_code;
   } rsp_type;

endpackage

`default_nettype wire

// ===== rtl/trsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface trsp_req_if;
   logic              valid;
   logic              ready;
   trsp_pkg::req_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface trsp_rsp_if;
   logic              valid;
   logic              ready;
   trsp_pkg::rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tagged_reply_stream_parser.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Byte-serial parser for a RESP-like reply stream. Every request carries one
// byte and yields exactly one result that classifies it (tag, length, payload,
// CR, LF or discarded) together with the value kind, the array nesting depth,
// completion flags, the assembled length and an error code. A byte is parsed
// from the parser state into the result register, so one request is taken
// per clock; the result register is freed in the same cycle it is read, and
// the only stall comes from the result side holding rsp ready low. The result
// is registered and appears in the cycle after its request is accepted. Open
// arrays sit in a stack of MAX_NEST_DEPTH element counts; closing any number
// of nested arrays on one byte is resolved combinationally as it is accepted.
module tagged_reply_stream_parser #(
   parameter int MAX_NEST_DEPTH = 8
) (
   input wire logic   clock,
   input wire logic   reset,
   trsp_req_if.sink   req_ch,
   trsp_rsp_if.source rsp_ch
);

   localparam int SPW = $clog2(MAX_NEST_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_TAG,
      PH_SIMPLE,
      PH_LEN,
      PH_HDR_CR,
      PH_HDR_LF,
      PH_DATA,
      PH_END_CR,
      PH_END_LF,
      PH_DISCARD
   } phase_type;

   phase_type         phase_ff, phase_in;
   logic [2:0]        kind_ff, kind_in;
   logic [31:0]       acc_ff, acc_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic [31:0]       rem_ff, rem_in;
   logic [SPW-1:0]    sp_ff, sp_in;
   logic [31:0]       stk_ff [MAX_NEST_DEPTH];
   logic              rsp_valid_ff;
   trsp_pkg::rsp_type rsp_data_ff, rsp_in;

   logic              accept;
   logic [7:0]        b;
   logic              discarded;
   logic              err_any;
   logic              fin;
   logic              push;
   logic [SPW-1:0]    fin_sp;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;
   assign b            = req_ch.data.rx_byte;
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // Closing a value pops the open arrays on top of the stack whose count is down to one; the
   // deepest array left with more elements is the one that gets decremented.
   always_comb begin
      fin_sp = '0;
      for (int i = 0; i < MAX_NEST_DEPTH; i++) begin
         if (SPW'(i) < sp_ff && stk_ff[i] != 32'd1) begin
            fin_sp = SPW'(i + 1);
         end
      end
   end

   always_comb begin
      phase_in  = phase_ff;
      kind_in   = kind_ff;
      acc_in    = acc_ff;
      cnt_in    = cnt_ff;
      rem_in    = rem_ff;
      sp_in     = sp_ff;
      fin       = 1'b0;
      push      = 1'b0;
      discarded = 1'b0;

      rsp_in              = '0;
      rsp_in.byte_role    = trsp_pkg::ROLE_DISCARD;
      rsp_in.value_kind   = kind_ff;
      rsp_in.nest_depth   = 4'(sp_ff);
      rsp_in.error_code   = trsp_pkg::ERR_OK;

      case (phase_ff)
         PH_TAG: begin
            rsp_in.byte_role = trsp_pkg::ROLE_TAG;
            acc_in = '0;
            cnt_in = '0;
            rem_in = '0;
            case (b)
               trsp_pkg::CH_SIMPLE: begin
                  kind_in  = trsp_pkg::KIND_SIMPLE;
                  phase_in = PH_SIMPLE;
               end
               trsp_pkg::CH_ERROR: begin
                  kind_in  = trsp_pkg::KIND_ERROR;
                  phase_in = PH_SIMPLE;
               end
               trsp_pkg::CH_INT: begin
                  kind_in  = trsp_pkg::KIND_INT;
                  rem_in   = trsp_pkg::INT_PAYLOAD_BYTES;
                  phase_in = PH_DATA;
               end
               trsp_pkg::CH_NULL: begin
                  kind_in  = trsp_pkg::KIND_NULL;
                  phase_in = PH_END_CR;
               end
               trsp_pkg::CH_BULK: begin
                  kind_in  = trsp_pkg::KIND_BULK;
                  phase_in = PH_LEN;
               end
               trsp_pkg::CH_ARRAY: begin
                  kind_in  = trsp_pkg::KIND_ARRAY;
                  phase_in = PH_LEN;
               end
               default: begin
                  rsp_in.error_code = trsp_pkg::ERR_BAD_TAG;
                  rsp_in.byte_role  = trsp_pkg::ROLE_DISCARD;
               end
            endcase
            rsp_in.value_kind = kind_in;
         end
         PH_SIMPLE: begin
            if (b == trsp_pkg::CH_CR) begin
               rsp_in.byte_role = trsp_pkg::ROLE_CR;
               phase_in = PH_END_LF;
            end else begin
               rsp_in.byte_role    = trsp_pkg::ROLE_PAYLOAD;
               rsp_in.payload_byte = b;
            end
         end
         PH_LEN: begin
            rsp_in.byte_role = trsp_pkg::ROLE_LEN;
            acc_in = acc_ff | ({24'd0, b} << {cnt_ff, 3'b000});
            cnt_in = cnt_ff + 2'd1;
            if (cnt_ff == 2'd3) begin
               cnt_in = cnt_ff;
               rsp_in.length_value = acc_in;
               phase_in = PH_HDR_CR;
            end
         end
         PH_HDR_CR: begin
            rsp_in.length_value = acc_ff;
            if (b == trsp_pkg::CH_CR) begin
               rsp_in.byte_role = trsp_pkg::ROLE_CR;
               phase_in = PH_HDR_LF;
            end else begin
               rsp_in.error_code = trsp_pkg::ERR_BAD_CRLF;
            end
         end
         PH_HDR_LF: begin
            rsp_in.length_value = acc_ff;
            if (b != trsp_pkg::CH_LF) begin
               rsp_in.error_code = trsp_pkg::ERR_BAD_CRLF;
            end else begin
               rsp_in.byte_role = trsp_pkg::ROLE_LF;
               if (kind_ff == trsp_pkg::KIND_BULK) begin
                  rem_in   = acc_ff;
                  phase_in = (acc_ff == 32'd0) ? PH_END_CR : PH_DATA;
               end else if (acc_ff == 32'd0) begin
                  fin = 1'b1;
               end else if (sp_ff >= SPW'(MAX_NEST_DEPTH)) begin
                  rsp_in.error_code = trsp_pkg::ERR_TOO_DEEP;
               end else begin
                  push     = 1'b1;
                  sp_in    = sp_ff + SPW'(1);
                  phase_in = PH_TAG;
                  kind_in  = trsp_pkg::KIND_NONE;
               end
            end
         end
         PH_DATA: begin
            rsp_in.byte_role    = trsp_pkg::ROLE_PAYLOAD;
            rsp_in.payload_byte = b;
            if (rem_ff != 32'd0) begin
               rem_in = rem_ff - 32'd1;
            end
            if (rem_in == 32'd0) begin
               phase_in = PH_END_CR;
            end
         end
         PH_END_CR: begin
            if (b == trsp_pkg::CH_CR) begin
               rsp_in.byte_role = trsp_pkg::ROLE_CR;
               phase_in = PH_END_LF;
            end else begin
               rsp_in.error_code = trsp_pkg::ERR_BAD_CRLF;
            end
         end
         PH_END_LF: begin
            if (b == trsp_pkg::CH_LF) begin
               rsp_in.byte_role = trsp_pkg::ROLE_LF;
               fin = 1'b1;
            end else begin
               rsp_in.error_code = trsp_pkg::ERR_BAD_CRLF;
            end
         end
         default: begin
            discarded = 1'b1;
         end
      endcase

      if (fin) begin
         sp_in             = fin_sp;
         rsp_in.value_done = 1'b1;
         rsp_in.reply_done = (fin_sp == '0);
         phase_in          = PH_TAG;
         kind_in           = trsp_pkg::KIND_NONE;
      end

      err_any = (rsp_in.error_code != trsp_pkg::ERR_OK);
      if (err_any) begin
         phase_in = PH_DISCARD;
         if (rsp_in.byte_role == trsp_pkg::ROLE_DISCARD) begin
            rsp_in.value_kind   = trsp_pkg::KIND_NONE;
            rsp_in.payload_byte = '0;
            rsp_in.length_value = '0;
         end
      end

      if (discarded) begin
         rsp_in = '0;
         rsp_in.byte_role = trsp_pkg::ROLE_DISCARD;
      end

      if (req_ch.data.end_of_buffer) begin
         // A reply cut off by the end of the buffer is flagged on its last byte.
         if (!(phase_in == PH_TAG && sp_in == '0) && !discarded && !err_any) begin
            rsp_in.error_code = trsp_pkg::ERR_TRUNCATED;
         end
         phase_in = PH_TAG;
         kind_in  = trsp_pkg::KIND_NONE;
         acc_in   = '0;
         cnt_in   = '0;
         rem_in   = '0;
         sp_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_TAG;
         kind_ff      <= trsp_pkg::KIND_NONE;
         sp_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            kind_ff  <= kind_in;
            sp_ff    <= sp_in;
         end
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         acc_ff      <= acc_in;
         cnt_ff      <= cnt_in;
         rem_ff      <= rem_in;
         rsp_data_ff <= rsp_in;
      end
   end

   // Each stack entry is loaded on a push to its level and decremented when
   // it is the array that a finished value belongs to.
   for (genvar g = 0; g < MAX_NEST_DEPTH; g++) begin : g_stack
      always_ff @(posedge clock) begin
         if (accept && push && SPW'(g) == sp_ff) begin
            stk_ff[g] <= acc_ff;
         end else if (accept && fin && !req_ch.data.end_of_buffer
                      && SPW'(g + 1) == fin_sp) begin
            stk_ff[g] <= stk_ff[g] - 32'd1;
         end
      end
   end

endmodule

`default_nettype wire

// ===== dv/tb_tagged_reply_stream_parser.sv =====
`timescale 1ns / 1ps

module tb_tagged_reply_stream_parser;

   localparam int MAX_DEPTH = 8;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BYTES = 400;
   localparam int HOLD_AT_REQUEST = 150;
   localparam int HOLD_CYCLES = 250;

   typedef enum logic [3:0] {
      PH_TAG, PH_SIMPLE, PH_LEN, PH_HDR_CR, PH_HDR_LF,
      PH_DATA, PH_END_CR, PH_END_LF, PH_DISCARD
   } parse_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   trsp_req_if req_if ();
   trsp_rsp_if rsp_if ();

   tagged_reply_stream_parser #(.MAX_NEST_DEPTH(MAX_DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always #1 clock = ~clock;

   // Parser state mirrored by the testbench.
   parse_phase_type st_phase;
   logic [2:0]      st_kind;
   logic [31:0]     st_acc;
   logic [3:0]      st_len_count;
   logic [31:0]     st_left;
   logic [3:0]      st_sp;
   logic [31:0]     st_stack [MAX_DEPTH];
   logic            st_sticky;

   trsp_pkg::req_type pending_reqs [$];
   trsp_pkg::rsp_type expected_rsps [$];
   logic [7:0]  frame_q [$];
   int          burst_left [2];
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_left = 0;
   logic        hold_done = 1'b0;
   int          accepted_reqs = 0;
   int          mismatches = 0;
   int          cycles = 0;

   function automatic void restart_parser();
      st_phase = PH_TAG;
      st_kind = trsp_pkg::KIND_NONE;
      st_acc = '0;
      st_len_count = '0;
      st_left = '0;
      st_sp = '0;
      st_sticky = 1'b0;
   endfunction

   // Closes every array that the value just finished completes.
   function automatic void finish_value(output logic vd, output logic rd);
      logic       stop;
      logic [2:0] top;
      stop = 1'b0;
      vd = 1'b1;
      while (!stop && st_sp > 0 && st_sp <= MAX_DEPTH) begin
         top = 3'(st_sp - 4'd1);
         if (st_stack[top] > 0)
            st_stack[top] = st_stack[top] - 32'd1;
         if (st_stack[top] != 0)
            stop = 1'b1;
         else
            st_sp = st_sp - 4'd1;
      end
      rd = (st_sp == 0);
      st_phase = PH_TAG;
      st_kind = trsp_pkg::KIND_NONE;
   endfunction

   function automatic trsp_pkg::rsp_type parse_byte(input trsp_pkg::req_type r);
      trsp_pkg::rsp_type o;
      logic [7:0] b;
      logic       discarded;
      logic       clean;
      logic       vd;
      logic       rd;
      b = r.rx_byte;
      o = '0;
      o.byte_role = trsp_pkg::ROLE_DISCARD;
      discarded = 1'b0;
      if (st_sticky || st_phase == PH_DISCARD) begin
         discarded = 1'b1;
      end else begin
         o.nest_depth = st_sp;
         o.value_kind = st_kind;
         case (st_phase)
            PH_TAG: begin
               o.byte_role = trsp_pkg::ROLE_TAG;
               st_acc = '0;
               st_len_count = '0;
               st_left = '0;
               case (b)
                  trsp_pkg::CH_SIMPLE: begin
                     st_kind = trsp_pkg::KIND_SIMPLE;
                     st_phase = PH_SIMPLE;
                  end
                  trsp_pkg::CH_ERROR: begin
                     st_kind = trsp_pkg::KIND_ERROR;
                     st_phase = PH_SIMPLE;
                  end
                  trsp_pkg::CH_INT: begin
                     st_kind = trsp_pkg::KIND_INT;
                     st_left = trsp_pkg::INT_PAYLOAD_BYTES;
                     st_phase = PH_DATA;
                  end
                  trsp_pkg::CH_NULL: begin
                     st_kind = trsp_pkg::KIND_NULL;
                     st_phase = PH_END_CR;
                  end
                  trsp_pkg::CH_BULK: begin
                     st_kind = trsp_pkg::KIND_BULK;
                     st_phase = PH_LEN;
                  end
                  trsp_pkg::CH_ARRAY: begin
                     st_kind = trsp_pkg::KIND_ARRAY;
                     st_phase = PH_LEN;
                  end
                  default: begin
                     o.error_code = trsp_pkg::ERR_BAD_TAG;
                     o.byte_role = trsp_pkg::ROLE_DISCARD;
                  end
               endcase
               o.value_kind = st_kind;
            end
            PH_SIMPLE: begin
               if (b == trsp_pkg::CH_CR) begin
                  o.byte_role = trsp_pkg::ROLE_CR;
                  st_phase = PH_END_LF;
               end else begin
                  o.byte_role = trsp_pkg::ROLE_PAYLOAD;
                  o.payload_byte = b;
               end
            end
            PH_LEN: begin
               o.byte_role = trsp_pkg::ROLE_LEN;
               st_acc = st_acc | (32'(b) << (8 * st_len_count[1:0]));
               st_len_count = st_len_count + 4'd1;
               if (st_len_count >= 4) begin
                  st_len_count = 4'd4;
                  o.length_value = st_acc;
                  st_phase = PH_HDR_CR;
               end
            end
            PH_HDR_CR: begin
               o.length_value = st_acc;
               if (b == trsp_pkg::CH_CR) begin
                  o.byte_role = trsp_pkg::ROLE_CR;
                  st_phase = PH_HDR_LF;
               end else begin
                  o.error_code = trsp_pkg::ERR_BAD_CRLF;
               end
            end
            PH_HDR_LF: begin
               o.length_value = st_acc;
               if (b != trsp_pkg::CH_LF) begin
                  o.error_code = trsp_pkg::ERR_BAD_CRLF;
               end else begin
                  o.byte_role = trsp_pkg::ROLE_LF;
                  if (st_kind == trsp_pkg::KIND_BULK) begin
                     st_left = st_acc;
                     st_phase = (st_acc == 0) ? PH_END_CR : PH_DATA;
                  end else if (st_acc == 0) begin
                     finish_value(vd, rd);
                     o.value_done = vd;
                     o.reply_done = rd;
                  end else if (st_sp >= MAX_DEPTH) begin
                     o.error_code = trsp_pkg::ERR_TOO_DEEP;
                  end else begin
                     st_stack[3'(st_sp)] = st_acc;
                     st_sp = st_sp + 4'd1;
                     st_phase = PH_TAG;
                     st_kind = trsp_pkg::KIND_NONE;
                  end
               end
            end
            PH_DATA: begin
               o.byte_role = trsp_pkg::ROLE_PAYLOAD;
               o.payload_byte = b;
               if (st_left > 0)
                  st_left = st_left - 32'd1;
               if (st_left == 0)
                  st_phase = PH_END_CR;
            end
            PH_END_CR: begin
               if (b == trsp_pkg::CH_CR) begin
                  o.byte_role = trsp_pkg::ROLE_CR;
                  st_phase = PH_END_LF;
               end else begin
                  o.error_code = trsp_pkg::ERR_BAD_CRLF;
               end
            end
            PH_END_LF: begin
               if (b == trsp_pkg::CH_LF) begin
                  o.byte_role = trsp_pkg::ROLE_LF;
                  finish_value(vd, rd);
                  o.value_done = vd;
                  o.reply_done = rd;
               end else begin
                  o.error_code = trsp_pkg::ERR_BAD_CRLF;
               end
            end
            default: discarded = 1'b1;
         endcase
         if (o.error_code != trsp_pkg::ERR_OK) begin
            st_sticky = 1'b1;
            st_phase = PH_DISCARD;
            if (o.byte_role == trsp_pkg::ROLE_DISCARD) begin
               o.value_kind = trsp_pkg::KIND_NONE;
               o.payload_byte = '0;
               o.length_value = '0;
            end
         end
      end

      if (discarded) begin
         o = '0;
         o.byte_role = trsp_pkg::ROLE_DISCARD;
      end

      if (r.end_of_buffer) begin
         clean = !st_sticky && st_phase == PH_TAG && st_sp == 0;
         if (!clean && !discarded && o.error_code == trsp_pkg::ERR_OK)
            o.error_code = trsp_pkg::ERR_TRUNCATED;
         restart_parser();
      end
      return o;
   endfunction

   // Stimulus construction: replies are assembled in frame_q, then released
   // as one buffer with end_of_buffer optionally set on its last byte.
   function automatic void put(input logic [7:0] b);
      frame_q = {frame_q, b};
   endfunction

   function automatic void put_header(input logic [7:0] tag, input logic [31:0] n);
      put(tag);
      put(n[7:0]);
      put(n[15:8]);
      put(n[23:16]);
      put(n[31:24]);
      put(trsp_pkg::CH_CR);
      put(trsp_pkg::CH_LF);
   endfunction

   function automatic void flush(input logic eob);
      trsp_pkg::req_type item;
      for (int i = 0; i < frame_q.size(); i++) begin
         item.rx_byte = frame_q[i];
         item.end_of_buffer = eob && (i == frame_q.size() - 1);
         pending_reqs = {pending_reqs, item};
      end
      frame_q.delete();
   endfunction

   function automatic void gen_value(input int level);
      int         sel;
      int         n;
      logic [7:0] b;
      sel = $urandom_range(0, (level < 4) ? 5 : 4);
      case (sel)
         0: begin
            put($urandom_range(0, 1) ? trsp_pkg::CH_SIMPLE : trsp_pkg::CH_ERROR);
            n = $urandom_range(0, 6);
            repeat (n) begin
               b = 8'($urandom_range(0, 255));
               // Only CR ends a simple string, so keep it out of the body.
               if (b == trsp_pkg::CH_CR)
                  b = trsp_pkg::CH_LF;
               put(b);
            end
            put(trsp_pkg::CH_CR);
            put(trsp_pkg::CH_LF);
         end
         1: begin
            put(trsp_pkg::CH_INT);
            repeat (trsp_pkg::INT_PAYLOAD_BYTES) put(8'($urandom_range(0, 255)));
            put(trsp_pkg::CH_CR);
            put(trsp_pkg::CH_LF);
         end
         2: begin
            put(trsp_pkg::CH_NULL);
            put(trsp_pkg::CH_CR);
            put(trsp_pkg::CH_LF);
         end
         3, 4: begin
            n = $urandom_range(0, 10);
            put_header(trsp_pkg::CH_BULK, 32'(n));
            repeat (n) put(8'($urandom_range(0, 255)));
            put(trsp_pkg::CH_CR);
            put(trsp_pkg::CH_LF);
         end
         default: begin
            n = $urandom_range(0, 3);
            put_header(trsp_pkg::CH_ARRAY, 32'(n));
            repeat (n) gen_value(level + 1);
         end
      endcase
   endfunction

   // A chain of single-element arrays around one leaf value.
   function automatic void gen_chain(input int depth);
      repeat (depth) put_header(trsp_pkg::CH_ARRAY, 32'd1);
      gen_value(4);
   endfunction

   function automatic int pick_gap(input int side);
      int r;
      if (burst_left[side] > 0) begin
         burst_left[side] = burst_left[side] - 1;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst_left[side] = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(4, 25);
   endfunction

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatches++;
      if (mismatches <= 10)
         $display("mismatch at request %0d: %s expected %0h got %0h",
                  accepted_reqs, what, want, got);
   endtask

   task automatic compare_result(input trsp_pkg::rsp_type want,
                                 input trsp_pkg::rsp_type got);
      if (got.byte_role !== want.byte_role)
         note_mismatch("byte_role", 32'(want.byte_role), 32'(got.byte_role));
      if (got.value_kind !== want.value_kind)
         note_mismatch("value_kind", 32'(want.value_kind), 32'(got.value_kind));
      if (got.payload_byte !== want.payload_byte)
         note_mismatch("payload_byte", 32'(want.payload_byte), 32'(got.payload_byte));
      if (got.nest_depth !== want.nest_depth)
         note_mismatch("nest_depth", 32'(want.nest_depth), 32'(got.nest_depth));
      if (got.value_done !== want.value_done)
         note_mismatch("value_done", 32'(want.value_done), 32'(got.value_done));
      if (got.reply_done !== want.reply_done)
         note_mismatch("reply_done", 32'(want.reply_done), 32'(got.reply_done));
      if (got.length_value !== want.length_value)
         note_mismatch("length_value", want.length_value, got.length_value);
      if (got.error_code !== want.error_code)
         note_mismatch("error_code", 32'(want.error_code), 32'(got.error_code));
   endtask

   // Request driver.
   always @(posedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_if.ready) begin
         if (send_gap > 0 || pending_reqs.size() == 0) begin
            req_if.valid <= 1'b0;
            if (send_gap > 0)
               send_gap <= send_gap - 1;
         end else begin
            req_if.valid <= 1'b1;
            req_if.data <= pending_reqs.pop_front();
            send_gap <= pick_gap(0);
         end
      end
   end

   // Result side ready, idling after accepted results.
   always @(posedge clock) begin
      int gap;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         if (rsp_if.valid && rsp_if.ready)
            gap = pick_gap(1);
         else if (recv_gap > 0)
            gap = recv_gap - 1;
         else
            gap = 0;
         recv_gap <= gap;
         rsp_if.ready <= (gap == 0) && (hold_left == 0);
      end
   end

   // One long hold-off on the result side so the parser backs up.
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (!hold_done && accepted_reqs >= HOLD_AT_REQUEST) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // Monitor: predict on every accepted request, check every accepted result.
   always @(posedge clock) begin
      trsp_pkg::rsp_type want;
      trsp_pkg::rsp_type predicted;
      if (!reset) begin
         if (req_if.valid && req_if.ready) begin
            predicted = parse_byte(req_if.data);
            expected_rsps = {expected_rsps, predicted};
            accepted_reqs++;
         end
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
               note_mismatch("unexpected result", '0, 32'(rsp_if.data.byte_role));
            end else begin
               want = expected_rsps.pop_front();
               compare_result(want, rsp_if.data);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tagged_reply_stream_parser regression: fail");
         $finish;
      end
   end

   initial begin
      int directed_n;
      int nrep;
      int shape;
      int cut;
      req_if.valid = 1'b0;
      req_if.data = '0;
      rsp_if.ready = 1'b0;
      restart_parser();
      foreach (st_stack[i]) st_stack[i] = '0;

      // Every kind of value, an LF inside a simple string, empty bulk and array.
      put(trsp_pkg::CH_SIMPLE); put("a"); put(trsp_pkg::CH_LF); put("b");
      put(trsp_pkg::CH_CR); put(trsp_pkg::CH_LF);
      put(trsp_pkg::CH_ERROR); put(trsp_pkg::CH_CR); put(trsp_pkg::CH_LF);
      put(trsp_pkg::CH_INT);
      put(8'h00); put(8'hff); put(trsp_pkg::CH_CR); put(trsp_pkg::CH_LF);
      put(8'h55); put(8'haa); put(8'h01); put(8'h80);
      put(trsp_pkg::CH_CR); put(trsp_pkg::CH_LF);
      put(trsp_pkg::CH_NULL); put(trsp_pkg::CH_CR); put(trsp_pkg::CH_LF);
      put_header(trsp_pkg::CH_BULK, 32'd0); put(trsp_pkg::CH_CR); put(trsp_pkg::CH_LF);
      put_header(trsp_pkg::CH_ARRAY, 32'd0);
      flush(1'b1);
      // Largest count, then the buffer ends inside the array.
      put_header(trsp_pkg::CH_ARRAY, 32'hffff_ffff); put(trsp_pkg::CH_INT);
      flush(1'b1);
      // Buffer ends inside a bulk payload.
      put_header(trsp_pkg::CH_BULK, 32'd5); put("a");
      flush(1'b1);
      // Unknown tag, then a discarded byte ends the buffer.
      put("x"); put(trsp_pkg::CH_SIMPLE);
      flush(1'b1);
      put(trsp_pkg::CH_NULL); put("Q"); put(trsp_pkg::CH_CR);
      flush(1'b1);
      // Missing header CR on the buffer's last byte.
      put(trsp_pkg::CH_BULK); put(8'd1); put(8'd0); put(8'd0); put(8'd0); put("z");
      flush(1'b1);
      put(trsp_pkg::CH_SIMPLE); put("x"); put(trsp_pkg::CH_CR); put("y");
      flush(1'b1);
      // Full nesting closed by one byte, then one level too many.
      gen_chain(MAX_DEPTH);
      flush(1'b1);
      gen_chain(MAX_DEPTH + 1);
      flush(1'b1);
      directed_n = pending_reqs.size();

      while (pending_reqs.size() < directed_n + RANDOM_BYTES) begin
         nrep = $urandom_range(1, 3);
         repeat (nrep) begin
            if ($urandom_range(0, 11) == 0)
               gen_chain($urandom_range(6, MAX_DEPTH + 1));
            else
               gen_value(0);
         end
         shape = $urandom_range(0, 9);
         if (shape == 7) begin
            frame_q[$urandom_range(0, frame_q.size() - 1)] = 8'($urandom_range(0, 255));
         end else if (shape == 8) begin
            cut = $urandom_range(1, frame_q.size());
            while (frame_q.size() > cut)
               void'(frame_q.pop_back());
         end else if (shape == 9) begin
            frame_q.delete();
            repeat ($urandom_range(1, 8)) put(8'($urandom_range(0, 255)));
         end
         flush(shape >= 7 || $urandom_range(0, 9) < 6);
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (pending_reqs.size() != 0 || req_if.valid || expected_rsps.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);

      if (mismatches == 0)
         $display("tagged_reply_stream_parser regression: pass");
      else
         $display("tagged_reply_stream_parser regression: fail");
      $finish;
   end

endmodule
